// ===== rtl/core/ita_pkg.sv =====
// integer to ascii formatter: shared types, register codes, character constants
// and the digit-to-character function; no dependencies
`timescale 1ns / 1ps

package ita_pkg;

	// fixed field widths
	localparam int VALUE_W    = 64;
	localparam int CNT_W      = 7;
	localparam int BASE_W     = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// long division: quotient bits resolved per cycle
	localparam int DIV_BITS   = 8;
	localparam int DIV_STEPS  = VALUE_W / DIV_BITS;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUMBER_BASE = 3'd0,
		REG_FIELD_WIDTH = 3'd1,
		REG_MIN_DIGITS  = 3'd2,
		REG_PAD_MODE    = 3'd3,
		REG_SIGN_MODE   = 3'd4,
		REG_SHOW_PREFIX = 3'd5,
		REG_UPPER_CASE  = 3'd6,
		REG_MAX_LENGTH  = 3'd7
	} reg_idx_t;

	// pad modes, code 3 behaves as right alignment
	localparam logic [1:0] PAD_RIGHT = 2'd0;
	localparam logic [1:0] PAD_ZERO  = 2'd1;
	localparam logic [1:0] PAD_LEFT  = 2'd2;

	// sign modes
	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_MINUS = 2'd1;
	localparam logic [1:0] SIGN_PLUS  = 2'd2;
	localparam logic [1:0] SIGN_SPACE = 2'd3;

	// characters
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

	// register file contents
	typedef struct packed {
		logic [BASE_W-1:0] number_base;
		logic [CNT_W-1:0]  field_width;
		logic [CNT_W-1:0]  min_digits;
		logic [1:0]        pad_mode;
		logic [1:0]        sign_mode;
		logic              show_prefix;
		logic              upper_case;
		logic [CNT_W-1:0]  max_length;
	} cfg_t;

	// one formatted value, lengths of each run of the text
	typedef struct packed {
		logic [CNT_W-1:0]  lead;
		logic [CHAR_W-1:0] sign_char;
		logic              has_sign;
		logic [1:0]        pfx_len;
		logic [CNT_W-1:0]  zeros;
		logic [CNT_W-1:0]  place;
		logic [CNT_W-1:0]  trail;
		logic [CNT_W-1:0]  n_out;
		logic              upper;
	} job_t;

	// digit value to ascii
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base_ch;
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		base_ch = upper ? CH_UP_A : CH_LO_A;
		if (d < 4'd10)
			return CH_ZERO + ext;
		else
			return base_ch + ext - 8'd10;
	endfunction

endpackage

// ===== rtl/core/ita_if.sv =====
// integer to ascii formatter: input and output channel interfaces
// depends on ita_pkg
`timescale 1ns / 1ps

interface ita_in_if;
	import ita_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface ita_out_if;
	import ita_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/core/ita_front.sv =====
// integer to ascii formatter front: takes a word, works out sign and prefix,
// converts the magnitude to digits and sizes every run; depends on ita_pkg, ita_if
`timescale 1ns / 1ps

module ita_front #(
	parameter int MAX_DIGITS    = 64,
	parameter int MAX_OUT_CHARS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	ita_in_if.sink                                  in_ch,
	input  ita_pkg::cfg_t                           cfg,
	output logic                                    push_valid,
	input  logic                                    push_ready,
	output ita_pkg::job_t                           push_job,
	output logic [ita_pkg::DIGIT_W*MAX_DIGITS-1:0]  push_digits
);
	import ita_pkg::*;

	localparam int DGW = DIGIT_W * MAX_DIGITS;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_CALC, F_PUSH} f_state_t;

	f_state_t            state_q;
	logic [VALUE_W-1:0]  dv_q;
	logic [BASE_W-1:0]   rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    place_q;
	logic [DGW-1:0]      digits_q;
	logic [BASE_W-1:0]   base_q;
	logic [CHAR_W-1:0]   sign_char_q;
	logic                has_sign_q;
	logic [1:0]          pfx_q;
	job_t                job_q;

	// accept-time classification
	logic [VALUE_W-1:0]  val_u;
	logic                neg_c;
	logic [VALUE_W-1:0]  mag_c;
	logic [CHAR_W-1:0]   sign_char_c;
	logic [BASE_W-1:0]   base_c;
	logic [1:0]          pfx_c;

	always_comb begin
		val_u = in_ch.value;
		neg_c = val_u[VALUE_W-1] && (cfg.sign_mode != SIGN_NONE);
		mag_c = neg_c ? (VALUE_W'(0) - val_u) : val_u;
		case (cfg.sign_mode)
			SIGN_NONE:  sign_char_c = CH_NUL;
			SIGN_MINUS: sign_char_c = neg_c ? CH_MINUS : CH_NUL;
			SIGN_PLUS:  sign_char_c = neg_c ? CH_MINUS : CH_PLUS;
			default:    sign_char_c = neg_c ? CH_MINUS : CH_SPACE;
		endcase
		if (cfg.number_base < 5'd2)
			base_c = 5'd2;
		else if (cfg.number_base > 5'd16)
			base_c = 5'd16;
		else
			base_c = cfg.number_base;
		if (cfg.show_prefix && base_c == 5'd16)
			pfx_c = 2'd2;
		else if (cfg.show_prefix && base_c == 5'd8)
			pfx_c = 2'd1;
		else
			pfx_c = 2'd0;
	end

	// restoring long division, DIV_BITS quotient bits per cycle
	logic [BASE_W-1:0]   r_n;
	logic [VALUE_W-1:0]  d_n;

	always_comb begin
		r_n = rem_q;
		d_n = dv_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r_n = {r_n[BASE_W-2:0], d_n[VALUE_W-1]};
			d_n = {d_n[VALUE_W-2:0], 1'b0};
			if (r_n >= base_q) begin
				r_n    = r_n - base_q;
				d_n[0] = 1'b1;
			end
		end
	end

	// run lengths once the digit count is known
	logic [CNT_W-1:0]    wide_c;
	logic signed [8:0]   slack_c;
	logic signed [8:0]   zf_c;
	logic [CNT_W-1:0]    lead_c;
	logic [CNT_W-1:0]    trail_c;
	logic [CNT_W-1:0]    zeros_c;
	logic [8:0]          total_c;
	logic [CNT_W-1:0]    limit_c;
	logic [CNT_W-1:0]    nout_c;

	always_comb begin
		wide_c  = (cfg.min_digits > place_q) ? cfg.min_digits : place_q;
		slack_c = $signed({2'b00, cfg.field_width}) - $signed({2'b00, wide_c})
			- $signed({8'd0, has_sign_q}) - $signed({7'd0, pfx_q});
		zf_c    = $signed({2'b00, cfg.min_digits}) - $signed({2'b00, place_q});
		if (cfg.pad_mode == PAD_ZERO) begin
			if (zf_c < 0)
				zf_c = '0;
			zf_c    = zf_c + slack_c;
			slack_c = '0;
		end
		lead_c  = (cfg.pad_mode != PAD_LEFT && slack_c > 0) ? slack_c[CNT_W-1:0] : '0;
		trail_c = (cfg.pad_mode == PAD_LEFT && slack_c > 0) ? slack_c[CNT_W-1:0] : '0;
		zeros_c = (zf_c > 0) ? zf_c[CNT_W-1:0] : '0;
		total_c = 9'(lead_c) + 9'(has_sign_q) + 9'(pfx_q) + 9'(zeros_c)
			+ 9'(place_q) + 9'(trail_c);
		limit_c = (cfg.max_length > CNT_W'(MAX_OUT_CHARS)) ? CNT_W'(MAX_OUT_CHARS)
			: cfg.max_length;
		nout_c  = (total_c < {2'b00, limit_c}) ? total_c[CNT_W-1:0] : limit_c;
	end

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			place_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						step_q  <= '0;
						place_q <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						place_q <= place_q + 1'b1;
						if (d_n == '0 || place_q == CNT_W'(MAX_DIGITS - 1))
							state_q <= F_CALC;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				F_CALC: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_ch.valid) begin
			dv_q        <= mag_c;
			rem_q       <= '0;
			base_q      <= base_c;
			sign_char_q <= sign_char_c;
			has_sign_q  <= (sign_char_c != CH_NUL);
			pfx_q       <= pfx_c;
		end else if (state_q == F_DIV) begin
			dv_q <= d_n;
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				rem_q    <= '0;
				digits_q <= {digits_q[DGW-DIGIT_W-1:0], r_n[DIGIT_W-1:0]};
			end else begin
				rem_q <= r_n;
			end
		end
		if (state_q == F_CALC) begin
			job_q.lead      <= lead_c;
			job_q.sign_char <= sign_char_q;
			job_q.has_sign  <= has_sign_q;
			job_q.pfx_len   <= pfx_q;
			job_q.zeros     <= zeros_c;
			job_q.place     <= place_q;
			job_q.trail     <= trail_c;
			job_q.n_out     <= nout_c;
			job_q.upper     <= cfg.upper_case;
		end
	end

	assign in_ch.ready = (state_q == F_IDLE);
	assign push_valid  = (state_q == F_PUSH);
	assign push_job    = job_q;
	assign push_digits = digits_q;

endmodule

// ===== rtl/core/ita_queue.sv =====
// integer to ascii formatter: short register queue between front and back
// depends on nothing
`timescale 1ns / 1ps

module ita_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/core/ita_back.sv =====
// integer to ascii formatter back: walks the runs of one value and sends
// one character per word; depends on ita_pkg, ita_if
`timescale 1ns / 1ps

module ita_back #(
	parameter int MAX_DIGITS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    pop_valid,
	output logic                                    pop_ready,
	input  ita_pkg::job_t                           pop_job,
	input  logic [ita_pkg::DIGIT_W*MAX_DIGITS-1:0]  pop_digits,
	ita_out_if.source                               out_ch
);
	import ita_pkg::*;

	localparam int DGW = DIGIT_W * MAX_DIGITS;

	typedef enum logic [2:0] {
		B_IDLE, B_LEAD, B_SIGN, B_PFX, B_ZERO, B_DIGIT, B_TRAIL
	} b_state_t;

	b_state_t          state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic              ovalid_q;
	logic [CHAR_W-1:0] ochar_q;
	logic              olast_q;
	job_t              job_q;
	logic [DGW-1:0]    digits_q;

	logic              can_emit;
	logic              fire;
	logic [CHAR_W-1:0] cur_char;

	assign can_emit  = !ovalid_q || out_ch.ready;
	assign fire      = (state_q != B_IDLE) && (rem_q != '0) && (cnt_q != '0) && can_emit;
	assign pop_ready = (state_q == B_IDLE);

	// character of the current run
	always_comb begin
		case (state_q) inside
			B_LEAD, B_TRAIL: cur_char = CH_SPACE;
			B_SIGN:          cur_char = job_q.sign_char;
			B_PFX:           cur_char = (cnt_q == CNT_W'(job_q.pfx_len)) ? CH_ZERO
				: (job_q.upper ? CH_UP_X : CH_LO_X);
			B_ZERO:          cur_char = CH_ZERO;
			B_DIGIT:         cur_char = digit_ascii(digits_q[DIGIT_W-1:0], job_q.upper);
			default:         cur_char = CH_NUL;
		endcase
	end

	// run sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			ovalid_q <= 1'b0;
			ochar_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (fire) begin
				ovalid_q <= 1'b1;
				ochar_q  <= cur_char;
				olast_q  <= (rem_q == CNT_W'(1));
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						cnt_q   <= pop_job.lead;
						rem_q   <= pop_job.n_out;
						state_q <= B_LEAD;
					end
				end
				default: begin
					if (rem_q == '0) begin
						state_q <= B_IDLE;
					end else if (cnt_q == '0) begin
						unique case (state_q)
							B_LEAD: begin
								cnt_q   <= CNT_W'(job_q.has_sign);
								state_q <= B_SIGN;
							end
							B_SIGN: begin
								cnt_q   <= CNT_W'(job_q.pfx_len);
								state_q <= B_PFX;
							end
							B_PFX: begin
								cnt_q   <= job_q.zeros;
								state_q <= B_ZERO;
							end
							B_ZERO: begin
								cnt_q   <= job_q.place;
								state_q <= B_DIGIT;
							end
							B_DIGIT: begin
								cnt_q   <= job_q.trail;
								state_q <= B_TRAIL;
							end
							default: state_q <= B_IDLE;
						endcase
					end else if (fire) begin
						cnt_q <= cnt_q - 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
			endcase
		end
	end

	// job copy and digit shift line, most significant digit at the bottom
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			job_q    <= pop_job;
			digits_q <= pop_digits;
		end else if (fire && state_q == B_DIGIT) begin
			digits_q <= {{DIGIT_W{1'b0}}, digits_q[DGW-1:DIGIT_W]};
		end
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.out_char  = ochar_q;
	assign out_ch.last_char = olast_q;

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// integer to ascii formatter top level: register file, front, queue and back
// depends on ita_pkg, ita_if, ita_front, ita_queue, ita_back
//
//  port       | dir | handshake       | contents
//  -----------+-----+-----------------+-------------------------------------
//  in_ch      | in  | valid / ready   | value, 64-bit signed integer
//  out_ch     | out | valid / ready   | out_char (ascii), last_char
//  cfg_*      | in  | cfg_we only     | cfg_index selects, cfg_data writes
//
// the front accepts a word, converts it digit by digit in its long-division unit
// (8 quotient bits a cycle), then sizes the runs and hands the word over.
// the back sends one character per cycle while the output is ready; it sends
// none while it takes a word from the queue or steps between runs; front and
// back overlap through a two-word queue.
// arst_n clears control state and loads the register reset values.
// either side may stall at any time; a held output stalls the front only
// once the queue is full.
`timescale 1ns / 1ps

module integer_to_ascii_formatter #(
	parameter int MAX_DIGITS    = 64,
	parameter int MAX_OUT_CHARS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ita_in_if.sink                             in_ch,
	ita_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [ita_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ita_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ita_pkg::*;

	localparam int DGW   = DIGIT_W * MAX_DIGITS;
	localparam int JOB_W = $bits(job_t);
	localparam int Q_W   = JOB_W + DGW;

	cfg_t            cfg_q;
	reg_idx_t        idx;

	assign idx = reg_idx_t'(cfg_index);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_base <= 5'd10;
			cfg_q.field_width <= '0;
			cfg_q.min_digits  <= '0;
			cfg_q.pad_mode    <= PAD_RIGHT;
			cfg_q.sign_mode   <= SIGN_MINUS;
			cfg_q.show_prefix <= 1'b0;
			cfg_q.upper_case  <= 1'b0;
			cfg_q.max_length  <= 7'd64;
		end else if (cfg_we) begin
			unique case (idx)
				REG_NUMBER_BASE: cfg_q.number_base <= cfg_data[BASE_W-1:0];
				REG_FIELD_WIDTH: cfg_q.field_width <= cfg_data;
				REG_MIN_DIGITS:  cfg_q.min_digits  <= cfg_data;
				REG_PAD_MODE:    cfg_q.pad_mode    <= cfg_data[1:0];
				REG_SIGN_MODE:   cfg_q.sign_mode   <= cfg_data[1:0];
				REG_SHOW_PREFIX: cfg_q.show_prefix <= cfg_data[0];
				REG_UPPER_CASE:  cfg_q.upper_case  <= cfg_data[0];
				REG_MAX_LENGTH:  cfg_q.max_length  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front to queue
	logic            f_valid;
	logic            f_ready;
	job_t            f_job;
	logic [DGW-1:0]  f_digits;

	// queue to back
	logic            b_valid;
	logic            b_ready;
	logic [Q_W-1:0]  b_data;
	job_t            b_job;
	logic [DGW-1:0]  b_digits;

	ita_front #(
		.MAX_DIGITS    (MAX_DIGITS),
		.MAX_OUT_CHARS (MAX_OUT_CHARS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.cfg         (cfg_q),
		.push_valid  (f_valid),
		.push_ready  (f_ready),
		.push_job    (f_job),
		.push_digits (f_digits)
	);

	ita_queue #(
		.WIDTH (Q_W),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_job, f_digits}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	assign b_job    = job_t'(b_data[Q_W-1:DGW]);
	assign b_digits = b_data[DGW-1:0];

	ita_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job),
		.pop_digits (b_digits),
		.out_ch     (out_ch)
	);

endmodule

// ===== tb/integer_to_ascii_formatter_test.sv =====
// self-checking testbench for the integer to ascii formatter
// drives value words, checks every character against a predictor of the text or a typed expected text
// depends on ita_pkg, ita_if and integer_to_ascii_formatter
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
	import ita_pkg::*;

	localparam int  SETTLE_CYCLES  = 640;
	localparam int  LONG_HOLD      = 1500;
	localparam int  RANDOM_PHASES  = 10;
	localparam int  PHASE_WORDS    = 25;
	localparam int  PRESSURE_PHASE = 2;
	localparam int  MAX_REPORTS    = 50;

	// register value masks, in register index order
	localparam logic [6:0] REG_MASK [8] = '{7'h1F, 7'h7F, 7'h7F, 7'h03,
		7'h03, 7'h01, 7'h01, 7'h7F};

	typedef logic [7:0][6:0] reg_set_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	typedef struct {
		reg_set_t    regs;
		logic [63:0] value;
		bit          typed;
		string       text;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ita_in_if  in_bus ();
	ita_out_if out_bus ();

	integer_to_ascii_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register contents as the block holds them
	logic [6:0] shadow [8] = '{7'd10, 7'd0, 7'd0, 7'd0, 7'd1, 7'd0, 7'd0, 7'd64};

	text_char_t    awaited_text [$];
	directed_row_t directed_rows [$];
	int            error_count = 0;
	int            char_count  = 0;
	int            stall_left  = 0;
	bit            calm         = 1'b0;
	bit            hold_request = 1'b0;

	always #6 clk = ~clk;

	// run limit
	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		if (error_count < MAX_REPORTS)
			$display("mismatch: %s", msg);
		error_count++;
	endtask

	function automatic reg_set_t make_set(input int base, input int width, input int digits,
			input int pad, input int sgn, input int pfx, input int up, input int maxlen);
		return {7'(maxlen), 7'(up), 7'(pfx), 7'(sgn), 7'(pad), 7'(digits), 7'(width),
			7'(base)};
	endfunction

	function automatic void add_row(input reg_set_t regs, input logic [63:0] value,
			input bit typed, input string text);
		directed_row_t row;
		row.regs  = regs;
		row.value = value;
		row.typed = typed;
		row.text  = text;
		directed_rows.push_back(row);
	endfunction

	// printf-style text of one value under the current registers
	function automatic void format_integer(input logic [63:0] raw);
		logic [63:0] mag;
		logic [7:0]  sign_ch;
		logic [7:0]  digit_ch [64];
		logic [7:0]  text [$];
		logic [3:0]  d;
		logic        upper;
		bit          left;
		int          base, lim, pfx_len, place, zfill, wide, slack, n;
		mag     = raw;
		sign_ch = CH_NUL;
		upper   = shadow[REG_UPPER_CASE][0];
		left    = (shadow[REG_PAD_MODE] == PAD_LEFT);
		// out of range radix clamps to 2 or 16
		base = shadow[REG_NUMBER_BASE];
		if (base < 2) base = 2;
		if (base > 16) base = 16;
		lim = shadow[REG_MAX_LENGTH];
		if (lim > 64) lim = 64;
		// sign, most negative value keeps its magnitude in 64 bits
		if (shadow[REG_SIGN_MODE] != SIGN_NONE) begin
			if (raw[63]) begin
				sign_ch = CH_MINUS;
				mag = 64'd0 - raw;
			end else if (shadow[REG_SIGN_MODE] == SIGN_PLUS) begin
				sign_ch = CH_PLUS;
			end else if (shadow[REG_SIGN_MODE] == SIGN_SPACE) begin
				sign_ch = CH_SPACE;
			end
		end
		pfx_len = 0;
		if (shadow[REG_SHOW_PREFIX][0]) begin
			if (base == 16) pfx_len = 2;
			else if (base == 8) pfx_len = 1;
		end
		// digits, least significant first, at least one
		place = 0;
		do begin
			d = 4'(mag % 64'(base));
			if (d < 4'd10)
				digit_ch[place] = CH_ZERO + 8'(d);
			else
				digit_ch[place] = (upper ? CH_UP_A : CH_LO_A) + 8'(d) - 8'd10;
			mag = mag / 64'(base);
			place++;
		end while (mag != 64'd0 && place < 64);
		// fill lengths, zero-pad folds the slack into the zeros
		zfill = int'(shadow[REG_MIN_DIGITS]) - place;
		wide  = (int'(shadow[REG_MIN_DIGITS]) > place) ? int'(shadow[REG_MIN_DIGITS]) : place;
		slack = int'(shadow[REG_FIELD_WIDTH]) - wide - ((sign_ch != CH_NUL) ? 1 : 0) - pfx_len;
		if (shadow[REG_PAD_MODE] == PAD_ZERO) begin
			if (zfill < 0) zfill = 0;
			zfill += slack;
			slack = 0;
		end
		// assemble the whole text, then cut to the length limit
		if (!left)
			for (int k = 0; k < slack; k++) text.push_back(CH_SPACE);
		if (sign_ch != CH_NUL) text.push_back(sign_ch);
		if (pfx_len > 0) text.push_back(CH_ZERO);
		if (pfx_len == 2) text.push_back(upper ? CH_UP_X : CH_LO_X);
		for (int k = 0; k < zfill; k++) text.push_back(CH_ZERO);
		for (int k = place - 1; k >= 0; k--) text.push_back(digit_ch[k]);
		if (left)
			for (int k = 0; k < slack; k++) text.push_back(CH_SPACE);
		n = (text.size() < lim) ? text.size() : lim;
		for (int k = 0; k < n; k++)
			awaited_text.push_back('{ch: text[k], last: (k == n - 1)});
	endfunction

	function automatic logic [6:0] pick_reg(input int lo, input int hi);
		if ($urandom_range(0, 7) == 0)
			return 7'($urandom);
		return 7'($urandom_range(lo, hi));
	endfunction

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			1: v = 64'($urandom_range(0, 999));
			2: v = 64'd0 - 64'($urandom_range(1, 999));
			3: begin
				case ($urandom_range(0, 3))
					0: v = 64'd0;
					1: v = 64'h7FFF_FFFF_FFFF_FFFF;
					2: v = 64'h8000_0000_0000_0000;
					default: v = '1;
				endcase
			end
			4: v = v >> $urandom_range(0, 63);
			default: ;
		endcase
		return v;
	endfunction

	// offer one word, predict its text once it is taken
	task automatic send_value(input logic [63:0] v, input bit predict);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.value <= v;
		do @(posedge clk); while (!in_bus.ready);
		if (predict) format_integer(v);
	endtask

	// wait for all awaited text, then for a silent item still in flight
	task automatic drain_block();
		in_bus.valid <= 1'b0;
		for (int k = 0; k < 200000 && awaited_text.size() != 0; k++) @(posedge clk);
		if (awaited_text.size() != 0) begin
			flag_mismatch($sformatf("%0d characters never arrived", awaited_text.size()));
			awaited_text.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write every register whose value changes, only while idle
	task automatic load_settings(input reg_set_t s);
		drain_block();
		for (int r = 0; r < 8; r++) begin
			if ((s[r] & REG_MASK[r]) != shadow[r]) begin
				cfg_we    <= 1'b1;
				cfg_index <= r[CFG_IDX_W-1:0];
				cfg_data  <= s[r];
				@(posedge clk);
				shadow[r] = s[r] & REG_MASK[r];
			end
		end
		cfg_we <= 1'b0;
	endtask

	// output side: check each word, stall in bursts or for a long hold
	initial begin : char_sink
		text_char_t want;
		out_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready) begin
				if (awaited_text.size() == 0) begin
					flag_mismatch($sformatf("char %0d: unexpected %h last %b", char_count,
						out_bus.out_char, out_bus.last_char));
				end else begin
					want = awaited_text.pop_front();
					if (out_bus.out_char !== want.ch || out_bus.last_char !== want.last)
						flag_mismatch($sformatf("char %0d: got %h last %b, wanted %h last %b",
							char_count, out_bus.out_char, out_bus.last_char, want.ch,
							want.last));
				end
				char_count++;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	// main sequence
	initial begin : stimulus
		reg_set_t s;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_bus.valid = 1'b0;
		in_bus.value = '0;

		// directed table, the first rows run on reset values
		add_row(make_set(10, 0, 0, 0, 1, 0, 0, 64), 64'd0, 1, "0");
		add_row(make_set(10, 0, 0, 0, 1, 0, 0, 64), 64'h7FFF_FFFF_FFFF_FFFF, 1,
			"9223372036854775807");
		add_row(make_set(10, 0, 0, 0, 1, 0, 0, 64), 64'h8000_0000_0000_0000, 1,
			"-9223372036854775808");
		add_row(make_set(10, 0, 0, 0, 1, 0, 0, 64), '1, 1, "-1");
		add_row(make_set(10, 0, 0, 0, 0, 0, 0, 64), '1, 1, "18446744073709551615");
		add_row(make_set(2, 0, 0, 0, 0, 0, 0, 64), '1, 0, "");
		add_row(make_set(2, 0, 0, 0, 1, 0, 0, 64), 64'h8000_0000_0000_0000, 0, "");
		add_row(make_set(16, 0, 0, 0, 0, 1, 1, 64), 64'hDEAD_BEEF, 1, "0XDEADBEEF");
		add_row(make_set(16, 0, 0, 0, 0, 1, 0, 64), 64'd255, 1, "0xff");
		add_row(make_set(8, 0, 0, 0, 0, 1, 0, 64), 64'd8, 1, "010");
		add_row(make_set(8, 0, 0, 0, 2, 1, 0, 64), 64'd0, 0, "");
		add_row(make_set(0, 0, 0, 0, 1, 0, 0, 64), 64'd5, 1, "101");
		add_row(make_set(31, 0, 0, 0, 1, 0, 0, 64), 64'd255, 1, "ff");
		add_row(make_set(10, 6, 0, 0, 2, 0, 0, 64), 64'd42, 1, "   +42");
		add_row(make_set(10, 6, 0, 2, 3, 0, 0, 64), 64'd42, 1, " 42   ");
		add_row(make_set(10, 6, 0, 1, 1, 0, 0, 64), 64'd0 - 64'd42, 1, "-00042");
		add_row(make_set(10, 3, 5, 1, 1, 0, 0, 64), 64'd7, 0, "");
		add_row(make_set(10, 5, 0, 3, 1, 0, 0, 64), 64'd7, 0, "");
		add_row(make_set(10, 0, 4, 0, 1, 0, 0, 64), 64'd0, 1, "0000");
		add_row(make_set(10, 0, 0, 0, 1, 0, 0, 0), 64'd123, 1, "");
		add_row(make_set(10, 0, 0, 0, 1, 0, 0, 3), 64'd123456, 1, "123");
		add_row(make_set(10, 127, 0, 0, 1, 0, 0, 100), 64'd1, 0, "");
		add_row(make_set(10, 0, 127, 2, 1, 0, 0, 127), 64'd1, 0, "");
		add_row(make_set(16, 0, 0, 0, 0, 0, 1, 64), 64'hABCD_EF01_2345_6789, 1,
			"ABCDEF0123456789");
		add_row(make_set(16, 10, 0, 1, 2, 1, 0, 64), 64'd255, 0, "");

		// reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			load_settings(directed_rows[i].regs);
			if (directed_rows[i].typed)
				for (int k = 0; k < directed_rows[i].text.len(); k++)
					awaited_text.push_back('{ch: directed_rows[i].text[k],
						last: (k == directed_rows[i].text.len() - 1)});
			send_value(directed_rows[i].value, !directed_rows[i].typed);
		end

		// random phases: extremes, a long output hold, then mixed settings
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: s = make_set(2, 0, 0, PAD_RIGHT, SIGN_NONE, 0, 0, 1);
				1: s = make_set(16, 64, 64, PAD_LEFT, SIGN_SPACE, 1, 1, 64);
				PRESSURE_PHASE: s = make_set(10, 0, 0, PAD_RIGHT, SIGN_MINUS, 0, 0, 64);
				default: begin
					s[REG_NUMBER_BASE] = ($urandom_range(0, 2) == 0) ?
						($urandom_range(0, 1) ? 7'd16 : 7'd8) : pick_reg(2, 16);
					s[REG_FIELD_WIDTH] = pick_reg(0, 24);
					s[REG_MIN_DIGITS]  = pick_reg(0, 24);
					s[REG_PAD_MODE]    = pick_reg(0, 3);
					s[REG_SIGN_MODE]   = pick_reg(0, 3);
					s[REG_SHOW_PREFIX] = pick_reg(0, 1);
					s[REG_UPPER_CASE]  = pick_reg(0, 1);
					s[REG_MAX_LENGTH]  = $urandom_range(0, 1) ? 7'd64 : pick_reg(1, 64);
				end
			endcase
			load_settings(s);
			calm = (phase == RANDOM_PHASES - 1);
			if (phase == PRESSURE_PHASE)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++)
				send_value(pick_value(), 1'b1);
		end

		drain_block();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
